// ----- hdl/mma_pkg.sv -----
// Shared types and constants for the matrix multiply-accumulate block.
package mma_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned SIZE_W = 7;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  localparam logic [ACTION_W-1:0] ACT_LOAD_A = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_B = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_UPDATE_C = 2'd2;

  localparam logic signed [VALUE_W-1:0] RES_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] RES_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start_c;
    logic div_step;
    logic mac_setup;
    logic mac_issue;
    logic round;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic mac_last;
    logic pipe_empty;
    logic out_free;
  } status_t;

endpackage

// ----- hdl/mma_in_if.sv -----
// Input channel: one matrix element beat with its action code.
interface mma_in_if;
  import mma_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output action, output value, input ready);
  modport sink (input valid, input action, input value, output ready);
endinterface

// ----- hdl/mma_out_if.sv -----
// Output channel: one updated C element beat with its final-element flag.
interface mma_out_if;
  import mma_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  result;
  logic                       last;

  modport source (output valid, output result, output last, input ready);
  modport sink (input valid, input result, input last, output ready);
endinterface

// ----- hdl/mma_ctrl.sv -----
// Controller state machine that sequences loads, index split, dot product and output.
module mma_ctrl
  import mma_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [ACTION_W-1:0] in_action_i,
  input  status_t             status_i,
  output logic                in_ready_o,
  output cmd_t                cmd_o,
  output state_e              state_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (in_action_i == ACT_UPDATE_C)) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.div_last) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_d = ST_MAC;
      end
      ST_MAC: begin
        if (status_i.mac_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status_i.pipe_empty) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load_a = in_valid_i && (in_action_i == ACT_LOAD_A);
        cmd_o.load_b = in_valid_i && (in_action_i == ACT_LOAD_B);
        cmd_o.start_c = in_valid_i && (in_action_i == ACT_UPDATE_C);
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_SETUP: begin
        cmd_o.mac_setup = 1'b1;
      end
      ST_MAC: begin
        cmd_o.mac_issue = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
      end
      ST_OUT: begin
        cmd_o.out_load = status_i.out_free;
      end
      default: begin
      end
    endcase
  end

  assign state_o = state_q;

endmodule

// ----- hdl/mma_datapath.sv -----
// Datapath: element stores, load counters, index divider, multiply-accumulate and output register.
module mma_datapath
  import mma_pkg::*;
#(
  parameter int unsigned MAX_DIM = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  output status_t                    status_o,
  input  logic                       cfg_we_i,
  input  logic [SIZE_W-1:0]          cfg_data_i,
  input  logic signed [VALUE_W-1:0]  in_value_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic signed [VALUE_W-1:0]  out_result_o,
  output logic                       out_last_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned TW = AW + 1;
  localparam int unsigned DW = $clog2(MAX_DIM + 1);
  localparam int unsigned CW = (AW > 1) ? $clog2(AW) : 1;
  localparam int unsigned ACW = 65 + $clog2(MAX_DIM);
  localparam int unsigned SW = ACW - 15;
  localparam int unsigned PW = 2 * VALUE_W;

  function automatic logic [AW-1:0] clip_idx(logic [AW-1:0] cnt, logic [TW-1:0] tot);
    return ({1'b0, cnt} < tot) ? cnt : '0;
  endfunction

  function automatic logic [AW-1:0] step_idx(logic [AW-1:0] idx, logic [TW-1:0] tot);
    return (({1'b0, idx} + TW'(1)) >= tot) ? '0 : idx + AW'(1);
  endfunction

  logic signed [VALUE_W-1:0] left_mem [DEPTH];
  logic signed [VALUE_W-1:0] right_mem [DEPTH];

  logic [SIZE_W-1:0]         size_q, size_d;
  logic [DW-1:0]             dim;
  logic [TW-1:0]             total;

  logic [AW-1:0]             a_cnt_q, a_cnt_d, a_idx;
  logic [AW-1:0]             b_cnt_q, b_cnt_d, b_idx;
  logic [AW-1:0]             u_cnt_q, u_cnt_d, u_idx;

  logic signed [VALUE_W-1:0] c_q;
  logic                      last_q;
  logic [AW-1:0]             idx_q;
  logic [AW-1:0]             shift_q;
  logic [DW-1:0]             rem_q;
  logic [DW:0]               rem_trial;
  logic [CW-1:0]             div_cnt_q, div_cnt_d;

  logic [AW-1:0]             left_addr_q, right_addr_q;
  logic [DW-1:0]             k_q, k_d;
  logic signed [VALUE_W-1:0] left_rd_q, right_rd_q;
  logic                      rd_valid_q, prod_valid_q;
  logic signed [PW-1:0]      prod_q;
  logic signed [ACW-1:0]     acc_q;

  logic signed [SW-1:0]      sum;
  logic signed [VALUE_W-1:0] sat;
  logic signed [VALUE_W-1:0] res_q;

  logic                      out_valid_q, out_valid_d;
  logic signed [VALUE_W-1:0] out_result_q;
  logic                      out_last_q;

  always_comb begin
    if (size_q == '0) begin
      dim = DW'(1);
    end else if (int'(size_q) > MAX_DIM) begin
      dim = DW'(MAX_DIM);
    end else begin
      dim = DW'(size_q);
    end
    total = TW'(dim) * TW'(dim);
  end

  assign a_idx = clip_idx(a_cnt_q, total);
  assign b_idx = clip_idx(b_cnt_q, total);
  assign u_idx = clip_idx(u_cnt_q, total);

  assign size_d = cfg_we_i ? cfg_data_i : size_q;
  assign a_cnt_d = cmd_i.load_a ? step_idx(a_idx, total) : a_cnt_q;
  assign b_cnt_d = cmd_i.load_b ? step_idx(b_idx, total) : b_cnt_q;
  assign u_cnt_d = cmd_i.start_c ? step_idx(u_idx, total) : u_cnt_q;

  always_comb begin
    rem_trial = {rem_q, shift_q[AW-1]};
    if (rem_trial >= {1'b0, dim}) begin
      rem_trial = rem_trial - {1'b0, dim};
    end
  end

  always_comb begin
    div_cnt_d = div_cnt_q;
    if (cmd_i.start_c) begin
      div_cnt_d = CW'(AW - 1);
    end else if (cmd_i.div_step) begin
      div_cnt_d = div_cnt_q - CW'(1);
    end
  end

  always_comb begin
    k_d = k_q;
    if (cmd_i.mac_setup) begin
      k_d = '0;
    end else if (cmd_i.mac_issue) begin
      k_d = k_q + DW'(1);
    end
  end

  always_comb begin
    sum = SW'(acc_q >>> 16) + SW'(c_q);
    if (sum > SW'(RES_MAX)) begin
      sat = RES_MAX;
    end else if (sum < SW'(RES_MIN)) begin
      sat = RES_MIN;
    end else begin
      sat = VALUE_W'(sum);
    end
  end

  assign out_valid_d = cmd_i.out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
      a_cnt_q <= '0;
      b_cnt_q <= '0;
      u_cnt_q <= '0;
      div_cnt_q <= '0;
      k_q <= '0;
      rd_valid_q <= 1'b0;
      prod_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      size_q <= size_d;
      a_cnt_q <= a_cnt_d;
      b_cnt_q <= b_cnt_d;
      u_cnt_q <= u_cnt_d;
      div_cnt_q <= div_cnt_d;
      k_q <= k_d;
      rd_valid_q <= cmd_i.mac_issue;
      prod_valid_q <= rd_valid_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a) begin
      left_mem[a_idx] <= in_value_i;
    end
    if (cmd_i.load_b) begin
      right_mem[b_idx] <= in_value_i;
    end
    left_rd_q <= left_mem[left_addr_q];
    right_rd_q <= right_mem[right_addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_c) begin
      c_q <= in_value_i;
      idx_q <= u_idx;
      shift_q <= u_idx;
      rem_q <= '0;
      last_q <= ({1'b0, u_idx} == (total - TW'(1)));
    end else if (cmd_i.div_step) begin
      shift_q <= {shift_q[AW-1:0] << 1};
      rem_q <= rem_trial[DW-1:0];
    end
    if (cmd_i.mac_setup) begin
      left_addr_q <= idx_q - AW'(rem_q);
      right_addr_q <= AW'(rem_q);
      acc_q <= '0;
    end else begin
      if (cmd_i.mac_issue) begin
        left_addr_q <= left_addr_q + AW'(1);
        right_addr_q <= right_addr_q + AW'(dim);
      end
      if (prod_valid_q) begin
        acc_q <= acc_q + ACW'(prod_q);
      end
    end
    if (rd_valid_q) begin
      prod_q <= left_rd_q * right_rd_q;
    end
    if (cmd_i.round) begin
      res_q <= sat;
    end
    if (cmd_i.out_load) begin
      out_result_q <= res_q;
      out_last_q <= last_q;
    end
  end

  assign status_o.div_last = (div_cnt_q == '0);
  assign status_o.mac_last = (k_q == (dim - DW'(1)));
  assign status_o.pipe_empty = !rd_valid_q && !prod_valid_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_result_o = out_result_q;
  assign out_last_o = out_last_q;

endmodule

// ----- hdl/matrix_multiply_accumulate.sv -----
// Matrix multiply-accumulate top level: C += A*B over square Q16.16 matrices.
// Load beats for A or B are taken while idle and may arrive back to back.
// A C result comes from a bit-serial index split and one shared multiplier-accumulator
// over N terms; no further input beat is taken until that result has been loaded into
// the output register.
// Reset clears the load counters and sets the size register to 64; the stores start undefined.
module matrix_multiply_accumulate
  import mma_pkg::*;
#(
  parameter int unsigned MAX_DIM = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_data_i,
  mma_in_if.sink            in_i,
  mma_out_if.source         out_o
);

  cmd_t    cmd;
  status_t status;
  state_e  state;

  mma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .status_i    (status),
    .in_ready_o  (in_i.ready),
    .cmd_o       (cmd),
    .state_o     (state)
  );

  mma_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_value_i   (in_i.value),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_result_o (out_o.result),
    .out_last_o   (out_o.last)
  );

`ifndef SYNTH
  // A C beat holds off further input until its result has been computed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (in_i.action == ACT_UPDATE_C)) |=> !in_i.ready)
    else $error("input accepted while a C element is in progress");

  // Rounding only starts once the multiply-accumulate pipeline has drained.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.round |-> status.pipe_empty)
    else $error("rounding started before the accumulator settled");

  // Store writes never coincide with dot-product reads.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mac_issue |-> !(cmd.load_a || cmd.load_b))
    else $error("store write during dot-product read");

  // A new result only appears after the output stage of the sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> ($past(state) == ST_OUT))
    else $error("result beat raised outside the output stage");
`endif

endmodule
